### hdl/cpid_pkg.sv
`default_nettype none

package cpid_pkg;

   // Motor slot storage. A command's slot number is the low bits of the selection sum.
   localparam int SLOT_W      = 4;
   localparam int MOTOR_SLOTS = 1 << SLOT_W;

   // Working widths of the shared arithmetic unit.
   localparam int OPD_W  = 19;
   localparam int GAIN_W = 32;
   localparam int FRAC_W = 24;
   localparam int PROD_W = OPD_W + GAIN_W - FRAC_W;
   localparam int ACC_W  = 30;

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_POS_KP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_KI = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_KD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPD_KP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPD_KI = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPD_KD = 3'd5;

   localparam logic [GAIN_W-1:0] POS_KP_RESET = 32'd7549747;
   localparam logic [GAIN_W-1:0] POS_KI_RESET = 32'd336;
   localparam logic [GAIN_W-1:0] POS_KD_RESET = 32'd0;
   localparam logic [GAIN_W-1:0] SPD_KP_RESET = 32'd117440512;
   localparam logic [GAIN_W-1:0] SPD_KI_RESET = 32'd1342177;
   localparam logic [GAIN_W-1:0] SPD_KD_RESET = 32'd134217728;

   localparam logic FUNC_FEEDBACK = 1'b0;
   localparam logic FUNC_COMMAND  = 1'b1;

   localparam logic [1:0] KIND_M = 2'd0;
   localparam logic [1:0] KIND_G = 2'd1;

   localparam logic [1:0] MODE_POSITION = 2'd0;
   localparam logic [1:0] MODE_SPEED    = 2'd1;
   localparam logic [1:0] MODE_DIRECT   = 2'd2;
   localparam logic [1:0] MODE_ZERO     = 2'd3;

   localparam logic [10:0] FB_ID_FIRST = 11'h201;
   localparam logic [10:0] FB_ID_LAST  = 11'h208;
   localparam logic [10:0] TX_ID_LOW   = 11'h200;
   localparam logic [10:0] TX_ID_HIGH  = 11'h1FF;
   localparam logic [10:0] TX_ID_ALT   = 11'h2FF;
   localparam logic [10:0] TX_ID_NONE  = 11'h000;

   localparam logic signed [OPD_W-1:0] WRAP_HALF     = 19'sd4096;
   localparam logic signed [OPD_W-1:0] WRAP_FULL     = 19'sd8192;
   localparam logic signed [OPD_W-1:0] ANGLE_INT_LIM = 19'sd500;
   localparam logic signed [OPD_W-1:0] SPEED_INT_LIM = 19'sd800;
   localparam logic signed [ACC_W-1:0] ANGLE_OUT_LIM = 30'sd300;
   localparam logic signed [ACC_W-1:0] SPEED_OUT_LIM = 30'sd20000;

   typedef struct packed {
      logic               func;
      logic [10:0]        frame_id;
      logic [15:0]        feedback_angle;
      logic signed [15:0] feedback_speed;
      logic [1:0]         motor_kind;
      logic [3:0]         motor_number;
      logic [1:0]         mode;
      logic signed [15:0] direct_torque;
      logic signed [15:0] speed_demand;
      logic [12:0]        angle_demand;
   } req_type;

   typedef struct packed {
      logic [10:0]        tx_id;
      logic [63:0]        frame_data;
      logic signed [15:0] drive_value;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic issue;
   } mac_ctrl_type;

   function automatic logic signed [OPD_W-1:0] clamp_opd(
      input logic signed [OPD_W-1:0] v,
      input logic signed [OPD_W-1:0] lim
   );
      logic signed [OPD_W-1:0] r;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic signed [ACC_W-1:0] clamp_acc(
      input logic signed [ACC_W-1:0] v,
      input logic signed [ACC_W-1:0] lim
   );
      logic signed [ACC_W-1:0] r;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/cpid_mac.sv
`default_nettype none

module cpid_mac import cpid_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mac_ctrl_type            ctrl,
   input  wire logic signed [OPD_W-1:0] opd,
   input  wire logic [GAIN_W-1:0]       gain,
   output logic signed [ACC_W-1:0]      acc
);

   logic [OPD_W-1:0]          mag;
   logic [OPD_W+GAIN_W-1:0]   full;
   logic [PROD_W-1:0]         prod_in;
   logic [PROD_W-1:0]         prod_ff;
   logic                      neg_ff;
   logic                      pvld_ff;
   logic signed [ACC_W-1:0]   term;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   acc_ff;

   // Sign and magnitude, so that the truncated product rounds toward zero.
   always_comb begin
      mag     = opd[OPD_W-1] ? -opd : opd;
      full    = (OPD_W+GAIN_W)'(mag) * (OPD_W+GAIN_W)'(gain);
      prod_in = full[OPD_W+GAIN_W-1:FRAC_W];
   end

   always_comb begin
      term = ACC_W'(prod_ff);
      if (neg_ff) begin
         term = -term;
      end
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (pvld_ff) begin
         acc_in = acc_ff + term;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
         acc_ff  <= '0;
      end else begin
         pvld_ff <= ctrl.issue;
         acc_ff  <= acc_in;
      end
      if (ctrl.issue) begin
         prod_ff <= prod_in;
         neg_ff  <= opd[OPD_W-1];
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

### hdl/cascaded_pid_motor_current_command_unit.sv
// Channel   Direction  Ports                               Moves
// request   in         req_valid, req_stall, req_payload   feedback or command item
// response  out        rsp_valid, rsp_stall, rsp_payload   transmit id, frame, torque
// csr       in         csr_we, csr_index, csr_wdata        loop gain write
//
// A command in position mode runs the position loop and then the speed loop, speed mode
// only the speed loop, and direct or zero mode neither. A feedback request with a frame
// id from 0x201 to 0x208 is stored at once; the next request is taken in the following
// cycle. The single 19x32 multiplier forms each loop's three products in turn.
// Reset is synchronous and clears the gains to their defaults and all slot state to zero.
// While a response is stalled the block holds its next result until the output is free.
`default_nettype none

module cascaded_pid_motor_current_command_unit import cpid_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_payload,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [GAIN_W-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_MUL,
      ST_DRAIN,
      ST_CLAMP,
      ST_OUT
   } state_type;

   state_type                state_ff;
   logic                     loop_ff;      // high while the speed loop runs
   logic [1:0]               k_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic [1:0]               kind_ff;
   logic [3:0]               id_ff;
   logic [12:0]              tgt_angle_ff;
   logic signed [15:0]       tgt_speed_ff;
   logic signed [15:0]       torque_ff;
   logic signed [OPD_W-1:0]  e_ff;
   logic signed [OPD_W-1:0]  i_ff;
   logic signed [OPD_W-1:0]  d_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_payload_ff;

   logic [GAIN_W-1:0] pos_kp_ff, pos_ki_ff, pos_kd_ff;
   logic [GAIN_W-1:0] spd_kp_ff, spd_ki_ff, spd_kd_ff;

   logic [15:0]        meas_angle_ff  [MOTOR_SLOTS];
   logic signed [15:0] meas_speed_ff  [MOTOR_SLOTS];
   logic signed [10:0] angle_int_ff   [MOTOR_SLOTS];
   logic signed [16:0] angle_prev_ff  [MOTOR_SLOTS];
   logic signed [10:0] speed_int_ff   [MOTOR_SLOTS];
   logic signed [17:0] speed_prev_ff  [MOTOR_SLOTS];

   logic                     req_accept;
   logic                     fb_hit;
   logic [SLOT_W-1:0]        fb_slot;
   logic [SLOT_W-1:0]        cmd_slot;
   logic [10:0]              fb_off;
   logic [7:0]               slot_sum;

   logic signed [OPD_W-1:0]  ta_ext, ma_ext, ea_raw, ea_wrap, ea, ai_new, da;
   logic signed [OPD_W-1:0]  ts_ext, ms_ext, es, si_new, ds;
   logic signed [OPD_W-1:0]  e_in, i_in, d_in;
   logic signed [OPD_W-1:0]  mac_opd;
   logic [GAIN_W-1:0]        mac_gain;
   logic signed [ACC_W-1:0]  mac_acc;
   logic signed [ACC_W-1:0]  acc_sat;
   mac_ctrl_type             mac_ctrl;

   logic                     id_ok;
   logic [1:0]               pos;
   logic [10:0]              tx_id_in;
   logic [63:0]              frame_in;
   logic                     out_free;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Feedback slot and command slot selection.
   always_comb begin
      fb_hit  = (req_payload.frame_id >= FB_ID_FIRST) && (req_payload.frame_id <= FB_ID_LAST);
      fb_off  = req_payload.frame_id - FB_ID_FIRST;
      fb_slot = fb_off[SLOT_W-1:0];
      case (req_payload.motor_kind)
         KIND_M:  slot_sum = {4'b0, req_payload.motor_number} + 8'd255;
         KIND_G:  slot_sum = {4'b0, req_payload.motor_number} + 8'd3;
         default: slot_sum = 8'd0;
      endcase
      cmd_slot = slot_sum[SLOT_W-1:0];
   end

   // Error, integral and derivative terms of both loops for the current slot.
   always_comb begin
      ta_ext  = OPD_W'(tgt_angle_ff);
      ma_ext  = OPD_W'(meas_angle_ff[slot_ff]);
      ea_raw  = ta_ext - ma_ext;
      ea_wrap = (ea_raw > WRAP_HALF) ? ea_raw - WRAP_FULL : ea_raw;
      ea      = (ea_wrap < -WRAP_HALF) ? ea_wrap + WRAP_FULL : ea_wrap;
      ai_new  = clamp_opd(OPD_W'(angle_int_ff[slot_ff]) + ea, ANGLE_INT_LIM);
      da      = ea - OPD_W'(angle_prev_ff[slot_ff]);

      ts_ext  = OPD_W'(tgt_speed_ff);
      ms_ext  = OPD_W'(meas_speed_ff[slot_ff]);
      es      = ts_ext - ms_ext;
      si_new  = clamp_opd(OPD_W'(speed_int_ff[slot_ff]) + es, SPEED_INT_LIM);
      ds      = es - OPD_W'(speed_prev_ff[slot_ff]);

      e_in = loop_ff ? es : ea;
      i_in = loop_ff ? si_new : ai_new;
      d_in = loop_ff ? ds : da;
   end

   // Operand and gain for the shared multiplier.
   always_comb begin
      case (k_ff)
         2'd0: begin
            mac_opd  = e_ff;
            mac_gain = loop_ff ? spd_kp_ff : pos_kp_ff;
         end
         2'd1: begin
            mac_opd  = i_ff;
            mac_gain = loop_ff ? spd_ki_ff : pos_ki_ff;
         end
         default: begin
            mac_opd  = d_ff;
            mac_gain = loop_ff ? spd_kd_ff : pos_kd_ff;
         end
      endcase
      mac_ctrl.clear = (state_ff == ST_ERR);
      mac_ctrl.issue = (state_ff == ST_MUL);
      acc_sat = clamp_acc(mac_acc, loop_ff ? SPEED_OUT_LIM : ANGLE_OUT_LIM);
   end

   cpid_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .opd   (mac_opd),
      .gain  (mac_gain),
      .acc   (mac_acc)
   );

   // Transmit frame assembly.
   always_comb begin
      id_ok = (id_ff >= 4'd1) && (id_ff <= 4'd8);
      pos   = (id_ff <= 4'd4) ? 2'(id_ff - 4'd1) : 2'(id_ff - 4'd5);
      tx_id_in = TX_ID_NONE;
      if (kind_ff == KIND_M && id_ok) begin
         tx_id_in = (id_ff <= 4'd4) ? TX_ID_LOW : TX_ID_HIGH;
      end else if (kind_ff == KIND_G && id_ok) begin
         tx_id_in = (id_ff <= 4'd4) ? TX_ID_HIGH : TX_ID_ALT;
      end
      case (pos)
         2'd0:    frame_in = {torque_ff, 48'b0};
         2'd1:    frame_in = {16'b0, torque_ff, 32'b0};
         2'd2:    frame_in = {32'b0, torque_ff, 16'b0};
         default: frame_in = {48'b0, torque_ff};
      endcase
      if (!id_ok) begin
         frame_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loop_ff      <= 1'b0;
         k_ff         <= 2'd0;
         rsp_valid_ff <= 1'b0;
         pos_kp_ff    <= POS_KP_RESET;
         pos_ki_ff    <= POS_KI_RESET;
         pos_kd_ff    <= POS_KD_RESET;
         spd_kp_ff    <= SPD_KP_RESET;
         spd_ki_ff    <= SPD_KI_RESET;
         spd_kd_ff    <= SPD_KD_RESET;
         for (int s = 0; s < MOTOR_SLOTS; s++) begin
            meas_angle_ff[s] <= '0;
            meas_speed_ff[s] <= '0;
            angle_int_ff[s]  <= '0;
            angle_prev_ff[s] <= '0;
            speed_int_ff[s]  <= '0;
            speed_prev_ff[s] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_POS_KP: pos_kp_ff <= csr_wdata;
               CSR_POS_KI: pos_ki_ff <= csr_wdata;
               CSR_POS_KD: pos_kd_ff <= csr_wdata;
               CSR_SPD_KP: spd_kp_ff <= csr_wdata;
               CSR_SPD_KI: spd_ki_ff <= csr_wdata;
               CSR_SPD_KD: spd_kd_ff <= csr_wdata;
               default: ;
            endcase
         end

         // In the output state a freed register is refilled below instead.
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept && req_payload.func == FUNC_FEEDBACK) begin
                  if (fb_hit) begin
                     meas_angle_ff[fb_slot] <= req_payload.feedback_angle;
                     meas_speed_ff[fb_slot] <= req_payload.feedback_speed;
                  end
               end else if (req_accept) begin
                  slot_ff      <= cmd_slot;
                  kind_ff      <= req_payload.motor_kind;
                  id_ff        <= req_payload.motor_number;
                  tgt_angle_ff <= req_payload.angle_demand;
                  tgt_speed_ff <= req_payload.speed_demand;
                  loop_ff      <= (req_payload.mode == MODE_SPEED);
                  torque_ff    <= (req_payload.mode == MODE_DIRECT) ?
                                  req_payload.direct_torque : 16'sd0;
                  if (req_payload.mode == MODE_POSITION || req_payload.mode == MODE_SPEED)
                  begin
                     state_ff <= ST_ERR;
                  end else begin
                     state_ff <= ST_OUT;
                  end
               end
            end
            ST_ERR: begin
               e_ff <= e_in;
               i_ff <= i_in;
               d_ff <= d_in;
               k_ff <= 2'd0;
               // The operands are now held locally, so the slot state is updated here.
               if (loop_ff) begin
                  speed_int_ff[slot_ff]  <= 11'(si_new);
                  speed_prev_ff[slot_ff] <= 18'(es);
               end else begin
                  angle_int_ff[slot_ff]  <= 11'(ai_new);
                  angle_prev_ff[slot_ff] <= 17'(ea);
               end
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd2) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_CLAMP;
            end
            ST_CLAMP: begin
               if (loop_ff) begin
                  torque_ff <= 16'(acc_sat);
                  state_ff  <= ST_OUT;
               end else begin
                  tgt_speed_ff <= 16'(acc_sat);
                  loop_ff      <= 1'b1;
                  state_ff     <= ST_ERR;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff               <= 1'b1;
                  rsp_payload_ff.tx_id       <= tx_id_in;
                  rsp_payload_ff.frame_data  <= frame_in;
                  rsp_payload_ff.drive_value <= torque_ff;
                  state_ff                   <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

### hdl/cpid_checker.sv
`default_nettype none

module cpid_checker import cpid_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_payload,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_payload
);

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A command request keeps the block busy in the next cycle.
   a_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.func == FUNC_COMMAND) |=> req_stall)
      else $error("command request did not occupy the block");

   // A feedback request never produces a response.
   a_fb_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.func == FUNC_FEEDBACK && !rsp_valid)
      |=> !rsp_valid)
      else $error("feedback request produced a response");

   // A valid transmit id carries the torque in exactly one 16-bit lane.
   a_frame_lane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.tx_id != TX_ID_NONE) |->
         ((rsp_payload.frame_data[63:48] == rsp_payload.drive_value &&
           rsp_payload.frame_data[47:0] == 48'b0) ||
          (rsp_payload.frame_data[47:32] == rsp_payload.drive_value &&
           rsp_payload.frame_data[63:48] == 16'b0 &&
           rsp_payload.frame_data[31:0] == 32'b0) ||
          (rsp_payload.frame_data[31:16] == rsp_payload.drive_value &&
           rsp_payload.frame_data[63:32] == 32'b0 &&
           rsp_payload.frame_data[15:0] == 16'b0) ||
          (rsp_payload.frame_data[15:0] == rsp_payload.drive_value &&
           rsp_payload.frame_data[63:16] == 48'b0)))
      else $error("torque not packed into a single lane");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

endmodule

bind cascaded_pid_motor_current_command_unit cpid_checker u_cpid_checker (.*);

`default_nettype wire
